### rtl/repeating_timer_slot_scheduler_defines.svh
// assertion macros for the repeating timer slot scheduler checker
`ifndef REPEATING_TIMER_SLOT_SCHEDULER_DEFINES_SVH
`define REPEATING_TIMER_SLOT_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rtsched_pkg.sv
// shared constants and types of the repeating timer slot scheduler
package rtsched_pkg;

   localparam int SLOTS      = 8;
   localparam int TIME_BITS  = 16;
   localparam int MAX_RES    = 8;
   localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FIRE_CNT_W = $clog2(MAX_RES + 1);
   localparam int CMP_W      = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam int SEL_W      = 6;

   localparam logic [1:0] FUNC_TICK           = 2'd0;
   localparam logic [1:0] FUNC_START          = 2'd1;
   localparam logic [1:0] FUNC_CANCEL_SLOT    = 2'd2;
   localparam logic [1:0] FUNC_CANCEL_HANDLER = 2'd3;

   localparam logic [1:0] KIND_START_REPLY  = 2'd0;
   localparam logic [1:0] KIND_CANCEL_REPLY = 2'd1;
   localparam logic [1:0] KIND_FIRED        = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [15:0]          FIRE_COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0]           handler;
      logic [15:0]          arg;
      logic [15:0]          duration;
      logic [TIME_BITS-1:0] elapsed;
      logic signed [16:0]   rep_limit;
      logic [15:0]          fire_count;
   } slot_type;

   localparam int REC_W = $bits(slot_type);

   typedef struct packed {
      logic             load;
      logic             rd_en;
      logic [IDX_W-1:0] rd_idx;
      logic             finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_err;
   } dp_status_type;

endpackage

### rtl/repeating_timer_slot_scheduler.sv
// top level of the repeating timer slot scheduler
//
// channel    handshake                 payload
// request    start high, busy low      req_func req_handler_id req_arg_tag
//                                      req_interval req_repeat_req req_slot_sel
// response   rsp_strobe, one cycle     rsp_kind rsp_status rsp_slot
//                                      rsp_fired_handler rsp_fired_arg rsp_last
//
// a transaction goes from accept through check, the slot ram scan and drain to the last response;
// the scan reads one slot per cycle; rejected requests skip the scan and go from check to finish
// tick responses come out during the scan and at its end, one per cycle at most
// busy drops in the cycle the last response is shown, so the next start may overlap it
// reset clears the sequencer, the slot valid bits and the response strobe at once
// responses cannot be stalled; the block never waits on the receiver
module repeating_timer_slot_scheduler (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_handler_id,
   input  logic [15:0]        req_arg_tag,
   input  logic [15:0]        req_interval,
   input  logic signed [16:0] req_repeat_req,
   input  logic [5:0]         req_slot_sel,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_kind,
   output logic               rsp_status,
   output logic [5:0]         rsp_slot,
   output logic [7:0]         rsp_fired_handler,
   output logic [15:0]        rsp_fired_arg,
   output logic               rsp_last
);
   import rtsched_pkg::*;

   ctrl_cmd_type     cmd;
   dp_status_type    dp_status;
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic [REC_W-1:0] ram_wr_data;
   logic [REC_W-1:0] ram_rd_data;

   rtsched_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .cmd    (cmd)
   );

   rtsched_ram #(
      .WIDTH (REC_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_idx),
      .rd_data (ram_rd_data)
   );

   rtsched_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (dp_status),
      .req_func          (req_func),
      .req_handler_id    (req_handler_id),
      .req_arg_tag       (req_arg_tag),
      .req_interval      (req_interval),
      .req_repeat_req    (req_repeat_req),
      .req_slot_sel      (req_slot_sel),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_data       (ram_rd_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fired_arg     (rsp_fired_arg),
      .rsp_last          (rsp_last)
   );

endmodule

### rtl/rtsched_ram.sv
// generic single write port, single read port ram with registered read
module rtsched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rtsched_ctrl.sv
// sequencer: check, slot scan, drain and finish of one transaction
module rtsched_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  rtsched_pkg::dp_status_type  status,
   output rtsched_pkg::ctrl_cmd_type   cmd
);
   import rtsched_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      cmd.rd_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            idx_in   = '0;
            state_in = status.req_err ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/rtsched_dp.sv
// datapath: request latch, per-slot update, search results and result register
module rtsched_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  rtsched_pkg::ctrl_cmd_type        cmd,
   output rtsched_pkg::dp_status_type       status,
   input  logic [1:0]                       req_func,
   input  logic [7:0]                       req_handler_id,
   input  logic [15:0]                      req_arg_tag,
   input  logic [15:0]                      req_interval,
   input  logic signed [16:0]               req_repeat_req,
   input  logic [5:0]                       req_slot_sel,
   output logic                             ram_wr_en,
   output logic [rtsched_pkg::IDX_W-1:0]    ram_wr_addr,
   output logic [rtsched_pkg::REC_W-1:0]    ram_wr_data,
   input  logic [rtsched_pkg::REC_W-1:0]    ram_rd_data,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_kind,
   output logic                             rsp_status,
   output logic [5:0]                       rsp_slot,
   output logic [7:0]                       rsp_fired_handler,
   output logic [15:0]                      rsp_fired_arg,
   output logic                             rsp_last
);
   import rtsched_pkg::*;

   // latched request
   logic [1:0]         func_ff, func_in;
   logic [7:0]         hid_ff, hid_in;
   logic [15:0]        arg_ff, arg_in;
   logic [15:0]        iv_ff, iv_in;
   logic signed [16:0] rep_ff, rep_in;
   logic [SEL_W-1:0]   sel_ff, sel_in;

   // scan stage
   logic               s_vld_ff;
   logic [IDX_W-1:0]   s_idx_ff;
   logic               q_vld_ff;
   logic [SLOTS-1:0]   valid_ff, valid_in;

   // start search
   logic                 match_vld_ff, match_vld_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;
   logic [TIME_BITS-1:0] match_el_ff, match_el_in;
   logic                 free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;

   // pending fire
   logic                  pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic [7:0]            pend_h_ff, pend_h_in;
   logic [15:0]           pend_arg_ff, pend_arg_in;
   logic [FIRE_CNT_W-1:0] fire_cnt_ff, fire_cnt_in;

   // result register
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [5:0]  rsp_slot_ff, rsp_slot_in;
   logic [7:0]  rsp_h_ff, rsp_h_in;
   logic [15:0] rsp_arg_ff, rsp_arg_in;
   logic        rsp_last_ff, rsp_last_in;

   slot_type             rec, tick_rec, clr_rec, start_rec;
   logic [TIME_BITS-1:0] el_inc;
   logic                 due, fire, reload, hit;
   logic signed [17:0]   rep_m1;
   logic signed [17:0]   fc_ext;

   assign rec = q_vld_ff ? slot_type'(ram_rd_data) : '0;

   assign status.req_err =
      ((func_ff == FUNC_START) && (hid_ff == 8'd0)) ||
      ((func_ff == FUNC_CANCEL_SLOT) && ({1'b0, sel_ff} >= (SEL_W + 1)'(SLOTS))) ||
      ((func_ff == FUNC_CANCEL_HANDLER) && (hid_ff == 8'd0));

   // tick update of the slot in the scan stage
   assign el_inc = (rec.elapsed != TIME_MAX) ? rec.elapsed + 1'b1 : rec.elapsed;
   assign due    = (rec.handler != 8'd0) && (CMP_W'(el_inc) >= CMP_W'(rec.duration));
   assign fire   = due && (fire_cnt_ff < FIRE_CNT_W'(MAX_RES));
   assign rep_m1 = $signed({rec.rep_limit[16], rec.rep_limit}) - 18'sd1;
   assign fc_ext = $signed({2'b00, rec.fire_count});
   assign reload = (rec.rep_limit == -17'sd1) || (fc_ext < rep_m1);

   always_comb begin
      tick_rec         = rec;
      tick_rec.elapsed = el_inc;
      if (fire) begin
         if (reload) begin
            tick_rec.elapsed = '0;
            if (rec.fire_count != FIRE_COUNT_MAX) begin
               tick_rec.fire_count = rec.fire_count + 1'b1;
            end
         end else begin
            tick_rec.handler = 8'd0;
            tick_rec.arg     = 16'd0;
         end
      end
   end

   // cancel of the slot in the scan stage
   assign hit = (func_ff == FUNC_CANCEL_SLOT) ?
                ({1'b0, sel_ff} == (SEL_W + 1)'(s_idx_ff)) : (rec.handler == hid_ff);

   always_comb begin
      clr_rec         = '0;
      clr_rec.elapsed = rec.elapsed;
   end

   // record written by a successful start
   always_comb begin
      start_rec            = '0;
      start_rec.handler    = hid_ff;
      start_rec.arg        = arg_ff;
      start_rec.duration   = iv_ff;
      start_rec.rep_limit  = rep_ff;
      start_rec.elapsed    = match_vld_ff ? match_el_ff : '0;
   end

   always_comb begin
      func_in       = func_ff;
      hid_in        = hid_ff;
      arg_in        = arg_ff;
      iv_in         = iv_ff;
      rep_in        = rep_ff;
      sel_in        = sel_ff;
      valid_in      = valid_ff;
      match_vld_in  = match_vld_ff;
      match_idx_in  = match_idx_ff;
      match_el_in   = match_el_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      pend_h_in     = pend_h_ff;
      pend_arg_in   = pend_arg_ff;
      fire_cnt_in   = fire_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_arg_in    = rsp_arg_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = s_idx_ff;
      ram_wr_data   = REC_W'(tick_rec);

      if (cmd.load) begin
         func_in      = req_func;
         hid_in       = req_handler_id;
         arg_in       = req_arg_tag;
         iv_in        = req_interval;
         rep_in       = req_repeat_req;
         sel_in       = req_slot_sel;
         match_vld_in = 1'b0;
         free_vld_in  = 1'b0;
         pend_vld_in  = 1'b0;
         fire_cnt_in  = '0;
      end

      if (s_vld_ff) begin
         case (func_ff)
            FUNC_TICK: begin
               ram_wr_en   = 1'b1;
               ram_wr_data = REC_W'(tick_rec);
               if (fire) begin
                  fire_cnt_in = fire_cnt_ff + 1'b1;
                  if (pend_vld_ff) begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_FIRED;
                     rsp_status_in = STATUS_OK;
                     rsp_slot_in   = 6'(pend_idx_ff);
                     rsp_h_in      = pend_h_ff;
                     rsp_arg_in    = pend_arg_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_idx_in = s_idx_ff;
                  pend_h_in   = rec.handler;
                  pend_arg_in = rec.arg;
               end
            end
            FUNC_START: begin
               if (!match_vld_ff && (rec.handler == hid_ff) && (rec.arg == arg_ff)) begin
                  match_vld_in = 1'b1;
                  match_idx_in = s_idx_ff;
                  match_el_in  = rec.elapsed;
               end
               if (!free_vld_ff && (rec.handler == 8'd0)) begin
                  free_vld_in = 1'b1;
                  free_idx_in = s_idx_ff;
               end
            end
            default: begin
               if (hit) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = REC_W'(clr_rec);
               end
            end
         endcase
      end

      if (cmd.finish) begin
         rsp_h_in    = 8'd0;
         rsp_arg_in  = 16'd0;
         rsp_slot_in = 6'd0;
         rsp_last_in = 1'b1;
         case (func_ff)
            FUNC_TICK: begin
               if (pend_vld_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_kind_in   = KIND_FIRED;
                  rsp_status_in = STATUS_OK;
                  rsp_slot_in   = 6'(pend_idx_ff);
                  rsp_h_in      = pend_h_ff;
                  rsp_arg_in    = pend_arg_ff;
               end
            end
            FUNC_START: begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_START_REPLY;
               if (!status.req_err && (match_vld_ff || free_vld_ff)) begin
                  rsp_status_in = STATUS_OK;
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = match_vld_ff ? match_idx_ff : free_idx_ff;
                  ram_wr_data   = REC_W'(start_rec);
                  rsp_slot_in   = 6'(ram_wr_addr);
               end else begin
                  rsp_status_in = STATUS_ERR;
               end
            end
            default: begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = KIND_CANCEL_REPLY;
               rsp_status_in = status.req_err ? STATUS_ERR : STATUS_OK;
            end
         endcase
      end

      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff      <= 1'b0;
         q_vld_ff      <= 1'b0;
         valid_ff      <= '0;
         match_vld_ff  <= 1'b0;
         free_vld_ff   <= 1'b0;
         pend_vld_ff   <= 1'b0;
         fire_cnt_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s_vld_ff      <= cmd.rd_en;
         if (cmd.rd_en) begin
            q_vld_ff <= valid_ff[cmd.rd_idx];
         end
         valid_ff      <= valid_in;
         match_vld_ff  <= match_vld_in;
         free_vld_ff   <= free_vld_in;
         pend_vld_ff   <= pend_vld_in;
         fire_cnt_ff   <= fire_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      hid_ff        <= hid_in;
      arg_ff        <= arg_in;
      iv_ff         <= iv_in;
      rep_ff        <= rep_in;
      sel_ff        <= sel_in;
      s_idx_ff      <= cmd.rd_idx;
      match_idx_ff  <= match_idx_in;
      match_el_ff   <= match_el_in;
      free_idx_ff   <= free_idx_in;
      pend_idx_ff   <= pend_idx_in;
      pend_h_ff     <= pend_h_in;
      pend_arg_ff   <= pend_arg_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_h_ff      <= rsp_h_in;
      rsp_arg_ff    <= rsp_arg_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_fired_handler = rsp_h_ff;
   assign rsp_fired_arg     = rsp_arg_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

### rtl/rtsched_checker.sv
// port-level assertions for the repeating timer slot scheduler, bound to the top level
`include "repeating_timer_slot_scheduler_defines.svh"

module rtsched_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input logic [1:0]         rsp_kind,
   input logic               rsp_status,
   input logic [7:0]         rsp_fired_handler,
   input logic               rsp_last
);
   import rtsched_pkg::*;

   // accepted transaction makes the block busy
   `RTS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
      "busy did not rise after an accepted transaction")

   // nothing follows the last response directly
   `RTS_ASSERT_NEXT(a_last_gap, clock, reset, rsp_strobe && rsp_last, !rsp_strobe,
      "response right after a last response")

   // replies are single responses
   `RTS_ASSERT_NOW(a_reply_last, clock, reset, rsp_strobe && (rsp_kind != KIND_FIRED),
      rsp_last, "reply without last flag")

   // a fired slot always carries ok status and a live handler
   `RTS_ASSERT_NOW(a_fired_handler, clock, reset, rsp_strobe && (rsp_kind == KIND_FIRED),
      (rsp_status == STATUS_OK) && (rsp_fired_handler != 8'd0),
      "fired response with error status or null handler")

endmodule

bind repeating_timer_slot_scheduler rtsched_checker u_rtsched_checker (.*);

### tb/repeating_timer_slot_scheduler_checker.sv
// response checker and slot table predictor for the repeating timer slot scheduler
`timescale 1ns / 1ps

module repeating_timer_slot_scheduler_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_handler_id,
   input  logic [15:0]        req_arg_tag,
   input  logic [15:0]        req_interval,
   input  logic signed [16:0] req_repeat_req,
   input  logic [5:0]         req_slot_sel,
   input  logic               rsp_strobe,
   input  logic [1:0]         rsp_kind,
   input  logic               rsp_status,
   input  logic [5:0]         rsp_slot,
   input  logic [7:0]         rsp_fired_handler,
   input  logic [15:0]        rsp_fired_arg,
   input  logic               rsp_last,
   output int                 failures,
   output int                 outstanding
);

   import rtsched_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic        status;
      logic [5:0]  slot;
      logic [7:0]  fired_handler;
      logic [15:0] fired_arg;
      logic        last;
   } sched_rsp_type;

   slot_type      timer_tbl [SLOTS];
   sched_rsp_type due_rsp_q [$];

   function automatic sched_rsp_type sched_rsp(input logic [1:0] k, input logic st,
                                               input int idx, input logic [7:0] h,
                                               input logic [15:0] a, input logic lst);
      sched_rsp_type r;
      r.kind          = k;
      r.status        = st;
      r.slot          = 6'(idx);
      r.fired_handler = h;
      r.fired_arg     = a;
      r.last          = lst;
      return r;
   endfunction

   task automatic release_slot(input int idx);
      timer_tbl[idx].handler    = '0;
      timer_tbl[idx].arg        = '0;
      timer_tbl[idx].duration   = '0;
      timer_tbl[idx].rep_limit  = '0;
      timer_tbl[idx].fire_count = '0;
   endtask

   task automatic timer_table_step(input logic [1:0] fn, input logic [7:0] h,
                                   input logic [15:0] a, input logic [15:0] iv,
                                   input logic signed [16:0] rep, input logic [5:0] sel);
      int            hit;
      int            n;
      sched_rsp_type fired [$];
      case (fn)
         FUNC_START: begin
            hit = -1;
            if (h != 8'd0) begin
               for (int i = 0; i < SLOTS; i++)
                  if (hit < 0 && timer_tbl[i].handler == h && timer_tbl[i].arg == a)
                     hit = i;
               if (hit >= 0) begin
                  timer_tbl[hit].duration   = iv;
                  timer_tbl[hit].rep_limit  = rep;
                  timer_tbl[hit].fire_count = '0;
               end else begin
                  for (int i = 0; i < SLOTS; i++)
                     if (hit < 0 && timer_tbl[i].handler == 8'd0)
                        hit = i;
                  if (hit >= 0) begin
                     timer_tbl[hit].handler    = h;
                     timer_tbl[hit].arg        = a;
                     timer_tbl[hit].duration   = iv;
                     timer_tbl[hit].rep_limit  = rep;
                     timer_tbl[hit].fire_count = '0;
                     timer_tbl[hit].elapsed    = '0;
                  end
               end
            end
            if (hit >= 0)
               due_rsp_q.push_back(sched_rsp(KIND_START_REPLY, STATUS_OK, hit,
                                             8'd0, 16'd0, 1'b1));
            else
               due_rsp_q.push_back(sched_rsp(KIND_START_REPLY, STATUS_ERR, 0,
                                             8'd0, 16'd0, 1'b1));
         end
         FUNC_CANCEL_SLOT: begin
            if (int'(sel) >= SLOTS) begin
               due_rsp_q.push_back(sched_rsp(KIND_CANCEL_REPLY, STATUS_ERR, 0,
                                             8'd0, 16'd0, 1'b1));
            end else begin
               release_slot(int'(sel));
               due_rsp_q.push_back(sched_rsp(KIND_CANCEL_REPLY, STATUS_OK, 0,
                                             8'd0, 16'd0, 1'b1));
            end
         end
         FUNC_CANCEL_HANDLER: begin
            if (h == 8'd0) begin
               due_rsp_q.push_back(sched_rsp(KIND_CANCEL_REPLY, STATUS_ERR, 0,
                                             8'd0, 16'd0, 1'b1));
            end else begin
               for (int i = 0; i < SLOTS; i++)
                  if (timer_tbl[i].handler == h)
                     release_slot(i);
               due_rsp_q.push_back(sched_rsp(KIND_CANCEL_REPLY, STATUS_OK, 0,
                                             8'd0, 16'd0, 1'b1));
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++)
               if (timer_tbl[i].elapsed != TIME_MAX)
                  timer_tbl[i].elapsed = timer_tbl[i].elapsed + 1'b1;
            n = 0;
            for (int i = 0; i < SLOTS; i++) begin
               if (n < MAX_RES && timer_tbl[i].handler != 8'd0 &&
                   timer_tbl[i].elapsed >= timer_tbl[i].duration) begin
                  fired.push_back(sched_rsp(KIND_FIRED, STATUS_OK, i, timer_tbl[i].handler,
                                            timer_tbl[i].arg, 1'b0));
                  n++;
                  if ($signed(timer_tbl[i].rep_limit) == -1 ||
                      int'(timer_tbl[i].fire_count) < int'($signed(timer_tbl[i].rep_limit)) - 1)
                  begin
                     if (timer_tbl[i].fire_count != FIRE_COUNT_MAX)
                        timer_tbl[i].fire_count = timer_tbl[i].fire_count + 1'b1;
                     timer_tbl[i].elapsed = '0;
                  end else begin
                     timer_tbl[i].handler = '0;
                     timer_tbl[i].arg     = '0;
                  end
               end
            end
            if (n > 0)
               fired[n-1].last = 1'b1;
            foreach (fired[k])
               due_rsp_q.push_back(fired[k]);
         end
      endcase
   endtask

   always @(posedge clock) begin
      sched_rsp_type seen;
      sched_rsp_type want;
      if (reset) begin
         foreach (timer_tbl[i])
            timer_tbl[i] = '0;
         due_rsp_q.delete();
      end else begin
         if (rsp_strobe) begin
            seen = '{rsp_kind, rsp_status, rsp_slot, rsp_fired_handler, rsp_fired_arg, rsp_last};
            if (due_rsp_q.size() == 0) begin
               if (failures < 10)
                  $display("%0t: unexpected response kind=%0d status=%0d slot=%0d",
                           $realtime, seen.kind, seen.status, seen.slot,
                           " handler=%02h arg=%04h last=%0d",
                           seen.fired_handler, seen.fired_arg, seen.last);
               failures++;
            end else begin
               want = due_rsp_q.pop_front();
               if (seen !== want) begin
                  if (failures < 10)
                     $display("%0t: mismatch expected kind=%0d status=%0d slot=%0d",
                              $realtime, want.kind, want.status, want.slot,
                              " handler=%02h arg=%04h last=%0d,",
                              want.fired_handler, want.fired_arg, want.last,
                              " got kind=%0d status=%0d slot=%0d",
                              seen.kind, seen.status, seen.slot,
                              " handler=%02h arg=%04h last=%0d",
                              seen.fired_handler, seen.fired_arg, seen.last);
                  failures++;
               end
            end
         end
         if (start && !busy)
            timer_table_step(req_func, req_handler_id, req_arg_tag, req_interval,
                             req_repeat_req, req_slot_sel);
      end
      outstanding = due_rsp_q.size();
   end

endmodule

### tb/repeating_timer_slot_scheduler_tb.sv
// stimulus and verdict for the repeating timer slot scheduler
`timescale 1ns / 1ps

module repeating_timer_slot_scheduler_tb;

   import rtsched_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_func = FUNC_TICK;
   logic [7:0]         req_handler_id = '0;
   logic [15:0]        req_arg_tag = '0;
   logic [15:0]        req_interval = '0;
   logic signed [16:0] req_repeat_req = '0;
   logic [5:0]         req_slot_sel = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_kind;
   logic               rsp_status;
   logic [5:0]         rsp_slot;
   logic [7:0]         rsp_fired_handler;
   logic [15:0]        rsp_fired_arg;
   logic               rsp_last;
   int                 failures;
   int                 pending;
   logic               steady = 1'b0;

   always #5 clock = ~clock;

   repeating_timer_slot_scheduler uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_handler_id    (req_handler_id),
      .req_arg_tag       (req_arg_tag),
      .req_interval      (req_interval),
      .req_repeat_req    (req_repeat_req),
      .req_slot_sel      (req_slot_sel),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fired_arg     (rsp_fired_arg),
      .rsp_last          (rsp_last)
   );

   repeating_timer_slot_scheduler_checker rsp_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_handler_id    (req_handler_id),
      .req_arg_tag       (req_arg_tag),
      .req_interval      (req_interval),
      .req_repeat_req    (req_repeat_req),
      .req_slot_sel      (req_slot_sel),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_fired_handler (rsp_fired_handler),
      .rsp_fired_arg     (rsp_fired_arg),
      .rsp_last          (rsp_last),
      .failures          (failures),
      .outstanding       (pending)
   );

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (steady)
         return 0;
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 4);
      if (r < 95)
         return $urandom_range(5, 14);
      return $urandom_range(20, 60);
   endfunction

   // hold one transaction until accepted, then optionally drop start for a while
   task automatic issue(input logic [1:0] fn, input logic [7:0] h, input logic [15:0] a,
                        input logic [15:0] iv, input logic signed [16:0] rep,
                        input logic [5:0] sel);
      int gap;
      req_func       <= fn;
      req_handler_id <= h;
      req_arg_tag    <= a;
      req_interval   <= iv;
      req_repeat_req <= rep;
      req_slot_sel   <= sel;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      gap = idle_len();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      #2_000_000;
      $display("repeating_timer_slot_scheduler test failed");
      $finish;
   end

   initial begin
      int                 r;
      int                 waited;
      logic [1:0]         fn;
      logic [7:0]         h;
      logic [15:0]        a;
      logic [15:0]        iv;
      logic signed [16:0] rep;
      logic [5:0]         sel;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part
      issue(FUNC_TICK, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd0);
      issue(FUNC_START, 8'h00, 16'h1234, 16'd3, 17'sd1, 6'd0);
      issue(FUNC_CANCEL_HANDLER, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd0);
      issue(FUNC_CANCEL_SLOT, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd63);
      issue(FUNC_CANCEL_SLOT, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd8);
      issue(FUNC_CANCEL_SLOT, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd0);
      issue(FUNC_CANCEL_HANDLER, 8'h55, 16'h0000, 16'd0, 17'sd0, 6'd0);
      issue(FUNC_START, 8'hFF, 16'hFFFF, 16'd0, -17'sd1, 6'd0);
      issue(FUNC_START, 8'h01, 16'h0000, 16'd1, 17'sd0, 6'd0);
      issue(FUNC_START, 8'h02, 16'h0001, 16'd2, 17'h10000, 6'd0);
      issue(FUNC_START, 8'h03, 16'h0002, 16'hFFFF, 17'h0FFFF, 6'd0);
      issue(FUNC_START, 8'h04, 16'h0003, 16'd1, 17'sd2, 6'd0);
      issue(FUNC_TICK, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd0);
      issue(FUNC_TICK, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd0);
      // re-arm keeps elapsed time, so this one is already due
      issue(FUNC_START, 8'h03, 16'h0002, 16'd2, 17'sd1, 6'd0);
      issue(FUNC_TICK, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd0);
      for (int k = 0; k < 7; k++)
         issue(FUNC_START, 8'h10 + 8'(k), 16'h5A5A ^ 16'(k), 16'd0,
               (k % 2 == 1) ? -17'sd1 : 17'sd3, 6'd0);
      issue(FUNC_START, 8'h30, 16'h0007, 16'd1, 17'sd1, 6'd0);
      issue(FUNC_TICK, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd0);
      issue(FUNC_CANCEL_HANDLER, 8'hFF, 16'h0000, 16'd0, 17'sd0, 6'd0);
      issue(FUNC_CANCEL_SLOT, 8'h00, 16'h0000, 16'd0, 17'sd0, 6'd7);
      issue(FUNC_START, 8'h20, 16'h0001, 16'd4, -17'sd1, 6'd0);
      issue(FUNC_START, 8'h20, 16'h0002, 16'd4, -17'sd1, 6'd0);
      issue(FUNC_CANCEL_HANDLER, 8'h20, 16'h0000, 16'd0, 17'sd0, 6'd0);

      // random part
      for (int i = 0; i < 240; i++) begin
         if (i % 16 == 0)
            steady = ($urandom_range(0, 99) < 30);
         r = $urandom_range(0, 99);
         if (r < 40)
            fn = FUNC_TICK;
         else if (r < 75)
            fn = FUNC_START;
         else if (r < 87)
            fn = FUNC_CANCEL_SLOT;
         else
            fn = FUNC_CANCEL_HANDLER;
         r = $urandom_range(0, 99);
         if (r < 5)
            h = 8'h00;
         else if (r < 85)
            h = 8'($urandom_range(1, 6));
         else
            h = 8'($urandom_range(0, 255));
         a = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 3))
                                          : 16'($urandom_range(0, 65535));
         r = $urandom_range(0, 99);
         if (r < 70)
            iv = 16'($urandom_range(0, 4));
         else if (r < 90)
            iv = 16'($urandom_range(5, 20));
         else
            iv = 16'($urandom_range(0, 65535));
         r = $urandom_range(0, 99);
         if (r < 30)
            rep = -17'sd1;
         else if (r < 75)
            rep = 17'($urandom_range(0, 4));
         else if (r < 88)
            rep = 17'(-int'($urandom_range(2, 5)));
         else
            rep = 17'($urandom_range(0, 131071));
         sel = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 7))
                                            : 6'($urandom_range(0, 63));
         issue(fn, h, a, iv, rep, sel);
      end

      start <= 1'b0;
      @(posedge clock);
      waited = 0;
      while ((busy || pending != 0) && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("repeating_timer_slot_scheduler test passed");
      else
         $display("repeating_timer_slot_scheduler test failed");
      $finish;
   end

endmodule
